[hw/rtl/sorted_timer_queue_core_defines.svh]
// assertion macros for the sorted timer queue core
// used by files that assert; expects clk_i and rst_ni in scope
`ifndef SORTED_TIMER_QUEUE_CORE_DEFINES_SVH
`define SORTED_TIMER_QUEUE_CORE_DEFINES_SVH

// implication checked at every rising clock edge outside reset
`define STQ_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// invariant checked at every rising clock edge outside reset
`define STQ_ASSERT_ALWAYS(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

`endif

[hw/rtl/stq_pkg.sv]
// shared types and constants of the sorted timer queue
// no dependencies
`default_nettype none

package stq_pkg;

  localparam int unsigned StqScoreW    = 48;
  localparam int unsigned StqCountOutW = 7;
  localparam int unsigned StqCapacity  = 64;

  typedef enum logic [1:0] {
    CMD_INSERT     = 2'd0,
    CMD_REMOVE_MIN = 2'd1,
    CMD_REMOVE_KEY = 2'd2,
    CMD_NOP        = 2'd3
  } stq_cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_EMPTY     = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } stq_status_e;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic eval;       // capture compare flags against the key
    logic apply;      // update the held scores
    logic ins;        // insert the key at its sorted place
    logic shift;      // close a gap by taking the right neighbor
    logic shift_all;  // shift every cell (remove minimum)
  } stq_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/stq_cell.sv]
// one cell of the sorted chain: a held score and its compare flags
// depends on stq_pkg
`default_nettype none

module stq_cell import stq_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire stq_ctl_t             ctl_i,
  input  wire logic [StqScoreW-1:0] key_i,
  input  wire logic                 valid_i,
  input  wire logic                 left_lt_i,
  input  wire logic [StqScoreW-1:0] left_score_i,
  input  wire logic [StqScoreW-1:0] right_score_i,
  output logic      [StqScoreW-1:0] score_o,
  output logic                      lt_o,
  output logic                      first_o
);

  logic [StqScoreW-1:0] score_q, score_d;
  logic                 lt_q, lt_d;
  logic                 eq_q, eq_d;

  always_comb begin
    lt_d = lt_q;
    eq_d = eq_q;
    if (ctl_i.eval) begin
      lt_d = valid_i && (score_q < key_i);
      eq_d = valid_i && (score_q == key_i);
    end
  end

  always_comb begin
    score_d = score_q;
    if (ctl_i.apply && ctl_i.ins) begin
      if (!lt_q) begin
        score_d = left_lt_i ? key_i : left_score_i;
      end
    end else if (ctl_i.apply && ctl_i.shift && (ctl_i.shift_all || !lt_q)) begin
      score_d = right_score_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else begin
      lt_q <= lt_d;
      eq_q <= eq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    score_q <= score_d;
  end

  assign score_o = score_q;
  assign lt_o    = lt_q;
  // first held entry equal to the key: left neighbor is below the key
  assign first_o = eq_q && left_lt_i;

endmodule

`default_nettype wire

[hw/rtl/sorted_timer_queue_core.sv]
// sorted timer queue: an accepted start steps through eval and apply, then shows the done strobe
// one command at a time (eval, apply, then idle with result shown); a start is taken only in idle
// eval is the compare pass and apply is the update pass of the cell chain
// a new start is taken in the cycle the done strobe is shown; no result stall
// reset: async active low, clears count, sequencer and strobe; scores stay unknown
`default_nettype none

module sorted_timer_queue_core import stq_pkg::*; #(
  parameter int unsigned Capacity = StqCapacity
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  output logic                         busy_o,
  input  wire logic [1:0]              command_i,
  input  wire logic [StqScoreW-1:0]    score_value_i,
  output logic                         done_o,
  output logic      [1:0]              status_o,
  output logic                         min_valid_o,
  output logic      [StqScoreW-1:0]    min_score_o,
  output logic      [StqCountOutW-1:0] entry_count_o
);

  localparam int unsigned CntW = $clog2(Capacity + 1);

  // sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_EVAL  = 3'b010,
    ST_APPLY = 3'b100
  } stq_state_e;

  stq_state_e state_q, state_d;

  // latched request
  stq_cmd_e             cmd_q;
  logic [StqScoreW-1:0] key_q;

  // held entry count
  logic [CntW-1:0] held_q, held_d;

  // result strobe and status
  logic        done_q, done_d;
  stq_status_e status_q, status_d;

  // chain wiring
  stq_ctl_t             ctl;
  logic [StqScoreW-1:0] cell_score [Capacity];
  logic [Capacity-1:0]  cell_lt;
  logic [Capacity-1:0]  cell_first;
  logic                 found;
  logic                 is_full;
  logic                 is_empty;
  logic                 accept;

  assign accept   = start_i && (state_q == ST_IDLE);
  assign is_full  = (held_q == CntW'(Capacity));
  assign is_empty = (held_q == '0);
  assign found    = |cell_first;

  // sequencer and command decode
  always_comb begin
    state_d       = state_q;
    held_d        = held_q;
    done_d        = 1'b0;
    status_d      = status_q;
    ctl           = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        ctl.eval = 1'b1;
        state_d  = ST_APPLY;
      end
      ST_APPLY: begin
        ctl.apply = 1'b1;
        done_d    = 1'b1;
        status_d  = STATUS_OK;
        state_d   = ST_IDLE;
        unique case (cmd_q)
          CMD_INSERT: begin
            if (is_full) begin
              status_d = STATUS_FULL;
            end else begin
              ctl.ins = 1'b1;
              held_d  = held_q + CntW'(1);
            end
          end
          CMD_REMOVE_MIN: begin
            if (is_empty) begin
              status_d = STATUS_EMPTY;
            end else begin
              ctl.shift     = 1'b1;
              ctl.shift_all = 1'b1;
              held_d        = held_q - CntW'(1);
            end
          end
          CMD_REMOVE_KEY: begin
            if (is_empty) begin
              status_d = STATUS_EMPTY;
            end else if (found) begin
              ctl.shift = 1'b1;
              held_d    = held_q - CntW'(1);
            end else begin
              status_d = STATUS_NOT_FOUND;
            end
          end
          CMD_NOP: begin
            // unused code: report the current view
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      held_q   <= '0;
      done_q   <= 1'b0;
      status_q <= STATUS_OK;
    end else begin
      state_q  <= state_d;
      held_q   <= held_d;
      done_q   <= done_d;
      status_q <= status_d;
    end
  end

  // request payload needs no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= stq_cmd_e'(command_i);
      key_q <= score_value_i;
    end
  end

  // chain of cells, head on the left; head sees an always-below left neighbor
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic                 left_lt;
    logic [StqScoreW-1:0] left_score;
    logic [StqScoreW-1:0] right_score;

    if (i == 0) begin : g_head
      assign left_lt    = 1'b1;
      assign left_score = key_q;
    end else begin : g_body
      assign left_lt    = cell_lt[i-1];
      assign left_score = cell_score[i-1];
    end

    if (i == Capacity - 1) begin : g_tail
      assign right_score = cell_score[i];
    end else begin : g_mid
      assign right_score = cell_score[i+1];
    end

    stq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (ctl),
      .key_i         (key_q),
      .valid_i       (held_q > CntW'(i)),
      .left_lt_i     (left_lt),
      .left_score_i  (left_score),
      .right_score_i (right_score),
      .score_o       (cell_score[i]),
      .lt_o          (cell_lt[i]),
      .first_o       (cell_first[i])
    );
  end

  // result ports; state is stable while the strobe is shown
  logic [CntW+StqCountOutW-1:0] count_ext;
  assign count_ext = {{StqCountOutW{1'b0}}, held_q};

  assign busy_o        = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign min_valid_o   = !is_empty;
  assign min_score_o   = is_empty ? '0 : cell_score[0];
  assign entry_count_o = count_ext[StqCountOutW-1:0];

  // assertions
`include "sorted_timer_queue_core_defines.svh"

  `STQ_ASSERT_IMPLY(a_done_when_idle, done_o, !busy_o, "done strobe outside idle")
  `STQ_ASSERT_IMPLY(a_latency, accept, ##3 done_o, "result not delivered after three cycles")
  `STQ_ASSERT_ALWAYS(a_count_bound, held_q <= CntW'(Capacity), "entry count above capacity")
  `STQ_ASSERT_IMPLY(a_full_status, done_o && (status_o == STATUS_FULL), is_full,
                    "full status without a full queue")
  `STQ_ASSERT_IMPLY(a_head_sorted, held_q >= CntW'(2), cell_score[0] <= cell_score[1],
                    "head of chain out of order")

endmodule

`default_nettype wire

[dv/tb_sorted_timer_queue_core.sv]
// self-checking testbench of the sorted timer queue core: drives insert, remove and nop
// requests with bursty timing and checks every done strobe against a predicted queue
// depends on stq_pkg and sorted_timer_queue_core
`default_nettype none

module tb_sorted_timer_queue_core;
  timeunit 1ns;
  timeprecision 1ps;

  import stq_pkg::*;

  localparam int unsigned DirectedCount = 22;
  localparam int unsigned RandomItems   = 1100;
  localparam int unsigned CycleLimit    = 200000;

  // what one done strobe should show
  typedef struct {
    stq_status_e                status;
    bit                         min_valid;
    bit [StqScoreW-1:0]         min_score;
    bit [StqCountOutW-1:0]      entry_count;
  } queue_view_t;

  // predicted queue contents plus the views still owed by the block
  class timer_queue_scoreboard;
    bit [StqScoreW-1:0] held[$];
    queue_view_t        views_due[$];
    int unsigned        mismatches;
    int unsigned        results_seen;
    int unsigned        n_inserted;
    int unsigned        n_full;
    int unsigned        n_empty;
    int unsigned        n_not_found;
    int unsigned        peak_fill;

    // apply one accepted request to the predicted queue and queue its view
    function void note_request(stq_cmd_e cmd, bit [StqScoreW-1:0] key);
      queue_view_t v;
      int unsigned pos;
      v.status = STATUS_OK;
      pos = 0;
      case (cmd)
        CMD_INSERT: begin
          if (held.size() >= StqCapacity) begin
            v.status = STATUS_FULL;
          end else begin
            // new score goes ahead of equal ones
            while (pos < held.size() && held[pos] < key) pos++;
            held.insert(pos, key);
            n_inserted++;
          end
        end
        CMD_REMOVE_MIN: begin
          if (held.size() == 0) v.status = STATUS_EMPTY;
          else void'(held.pop_front());
        end
        CMD_REMOVE_KEY: begin
          if (held.size() == 0) begin
            v.status = STATUS_EMPTY;
          end else begin
            while (pos < held.size() && held[pos] < key) pos++;
            if (pos < held.size() && held[pos] == key) held.delete(pos);
            else v.status = STATUS_NOT_FOUND;
          end
        end
        default: ;
      endcase
      v.min_valid   = (held.size() > 0);
      v.min_score   = (held.size() > 0) ? held[0] : '0;
      v.entry_count = StqCountOutW'(held.size());
      if (v.status == STATUS_FULL) n_full++;
      if (v.status == STATUS_EMPTY) n_empty++;
      if (v.status == STATUS_NOT_FOUND) n_not_found++;
      if (held.size() > peak_fill) peak_fill = held.size();
      views_due.push_back(v);
    endfunction

    function void check_result(logic [1:0] status, logic min_valid,
                               logic [StqScoreW-1:0] min_score,
                               logic [StqCountOutW-1:0] entry_count);
      queue_view_t v;
      results_seen++;
      if (views_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: done strobe with no request outstanding (result %0d)",
                   results_seen);
        return;
      end
      v = views_due.pop_front();
      if (status !== v.status || min_valid !== v.min_valid ||
          min_score !== v.min_score || entry_count !== v.entry_count) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: result %0d differs", results_seen);
          $display("  expected status %0d valid %0d min %h count %0d",
                   v.status, v.min_valid, v.min_score, v.entry_count);
          $display("  actual   status %0d valid %0d min %h count %0d",
                   status, min_valid, min_score, entry_count);
        end
      end
    endfunction

    function void flag_leftover();
      if (views_due.size() != 0) begin
        mismatches += views_due.size();
        $display("ERROR: %0d results never arrived", views_due.size());
      end
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start_i;
  logic                    busy_o;
  logic [1:0]              command_i;
  logic [StqScoreW-1:0]    score_value_i;
  logic                    done_o;
  logic [1:0]              status_o;
  logic                    min_valid_o;
  logic [StqScoreW-1:0]    min_score_o;
  logic [StqCountOutW-1:0] entry_count_o;

  timer_queue_scoreboard sb;
  int unsigned           cycle_count;
  int unsigned           requests_sent;
  int unsigned           burst_left;

  sorted_timer_queue_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .command_i     (command_i),
    .score_value_i (score_value_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .min_valid_o   (min_valid_o),
    .min_score_o   (min_score_o),
    .entry_count_o (entry_count_o)
  );

  // 20 ns clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("ERROR: run exceeded %0d cycles", CycleLimit);
      $display("Mismatches found");
      $finish;
    end
  end

  // results cannot be held off, so every strobe is checked at the edge that ends it
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && done_o === 1'b1)
      sb.check_result(status_o, min_valid_o, min_score_o, entry_count_o);
  end

  // random score: extremes, small values for duplicates, held scores, full width
  function automatic bit [StqScoreW-1:0] rand_score();
    bit [63:0] wide;
    wide = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: wide = $urandom_range(0, 1) ? 64'hFFFF_FFFF_FFFF - $urandom_range(0, 2)
                                     : 64'($urandom_range(0, 2));
      1, 2: wide = 64'($urandom_range(0, 20));
      3: if (sb.held.size() != 0)
           wide = 64'(sb.held[$urandom_range(0, sb.held.size() - 1)]);
      default: ;
    endcase
    return wide[StqScoreW-1:0];
  endfunction

  // one request: hold start until the block takes it, then maybe pause
  task automatic issue(stq_cmd_e cmd, bit [StqScoreW-1:0] key);
    int unsigned gap;
    start_i       <= 1'b1;
    command_i     <= cmd;
    score_value_i <= key;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    sb.note_request(cmd, key);
    requests_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      // random gaps land on every phase of the eval, apply and idle sequence
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
      if (gap != 0) begin
        // fields are don't-care while start is low, so toss noise on them
        start_i       <= 1'b0;
        command_i     <= 2'($urandom_range(0, 3));
        score_value_i <= rand_score();
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    int unsigned      phase;
    int unsigned      len;
    int unsigned      roll;
    int unsigned      j;
    bit               fill;
    stq_cmd_e         cmd;
    bit [StqScoreW-1:0] key;

    sb            = new();
    burst_left    = 4;
    start_i       <= 1'b0;
    command_i     <= CMD_INSERT;
    score_value_i <= '0;
    rst_ni        <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty queue cases, extremes, duplicates, misses, unused code
    issue(CMD_REMOVE_MIN, '0);
    issue(CMD_REMOVE_KEY, '0);
    issue(CMD_NOP,        '0);
    issue(CMD_INSERT,     48'hFFFF_FFFF_FFFF);
    issue(CMD_INSERT,     48'h0);
    issue(CMD_INSERT,     48'd5);
    issue(CMD_INSERT,     48'd5);
    issue(CMD_INSERT,     48'h8000_0000_0000);
    issue(CMD_REMOVE_KEY, 48'd6);
    issue(CMD_REMOVE_KEY, 48'hFFFF_FFFF_FFFF);
    issue(CMD_REMOVE_KEY, 48'd5);
    issue(CMD_NOP,        48'hFFFF_FFFF_FFFF);
    issue(CMD_REMOVE_MIN, 48'd5);
    issue(CMD_REMOVE_KEY, 48'h7FFF_FFFF_FFFF);
    issue(CMD_INSERT,     48'hAAAA_AAAA_AAAA);
    issue(CMD_INSERT,     48'h5555_5555_5555);
    issue(CMD_REMOVE_KEY, 48'h5555_5555_5555);
    issue(CMD_REMOVE_MIN, '0);
    issue(CMD_REMOVE_MIN, '0);
    issue(CMD_REMOVE_MIN, '0);
    issue(CMD_REMOVE_MIN, '0);
    issue(CMD_NOP,        48'h1234_5678_9ABC);

    // random: alternate fill-heavy and drain-heavy phases so the queue keeps
    // running into full and back down to empty
    phase = 0;
    while (requests_sent < DirectedCount + RandomItems) begin
      fill = (phase % 2 == 0);
      len  = $urandom_range(60, 140);
      for (j = 0; j < len && requests_sent < DirectedCount + RandomItems; j++) begin
        roll = $urandom_range(0, 99);
        if (fill)
          cmd = (roll < 80) ? CMD_INSERT : (roll < 88) ? CMD_REMOVE_MIN :
                (roll < 97) ? CMD_REMOVE_KEY : CMD_NOP;
        else
          cmd = (roll < 12) ? CMD_INSERT : (roll < 55) ? CMD_REMOVE_MIN :
                (roll < 97) ? CMD_REMOVE_KEY : CMD_NOP;
        // remove by score mostly targets a held score
        if (cmd == CMD_REMOVE_KEY && sb.held.size() != 0 && $urandom_range(0, 9) < 7)
          key = sb.held[$urandom_range(0, sb.held.size() - 1)];
        else
          key = rand_score();
        issue(cmd, key);
      end
      phase++;
    end

    // drain: wait out the outstanding results, then let the clock run on before the leftover check
    start_i <= 1'b0;
    while (sb.views_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    sb.flag_leftover();

    $display("run covered %0d requests, %0d results checked, peak fill %0d of %0d",
             requests_sent, sb.results_seen, sb.peak_fill, StqCapacity);
    $display("inserts taken %0d, full refusals %0d, empty removes %0d, misses %0d",
             sb.n_inserted, sb.n_full, sb.n_empty, sb.n_not_found);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
